@@ rtl/vms_pkg.sv @@
// Shared widths and types for the von Mises equivalent stress pipeline.
package vms_pkg;

    // Tensor component width, signed Q16.16
    localparam int COMP_W = 32;
    // Product width of two components, Q32.32
    localparam int PROD_W = 2 * COMP_W;
    // Signed accumulator width for partial sums of the quadratic form
    localparam int ACC_W = PROD_W + 4;
    // Quadratic form width: below 2^66, always non-negative
    localparam int Q_W = PROD_W + 2;
    // Root width, unsigned Q17.16
    localparam int ROOT_W = 33;
    // Register stages in the quadratic form front end
    localparam int QUAD_STAGES = 4;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [Q_W-1:0]           t_quad;
    typedef logic [ROOT_W-1:0]        t_root;

endpackage

@@ rtl/vms_quad.sv @@
// Four-stage pipeline that forms the von Mises quadratic form exactly.
module vms_quad (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_kind,
    input  vms_pkg::t_comp    i_normal_x,
    input  vms_pkg::t_comp    i_normal_y,
    input  vms_pkg::t_comp    i_normal_z,
    input  vms_pkg::t_comp    i_shear_xy,
    input  vms_pkg::t_comp    i_shear_xz,
    input  vms_pkg::t_comp    i_shear_yz,
    output logic              o_valid,
    output vms_pkg::t_quad    o_q
);

    logic [vms_pkg::QUAD_STAGES-1:0] r_vld;

    // Plane tensors drop the out-of-plane components
    vms_pkg::t_comp n_sz;
    vms_pkg::t_comp n_txz;
    vms_pkg::t_comp n_tyz;

    // Stage 1: products
    vms_pkg::t_prod r_p_xx, r_p_yy, r_p_zz;
    vms_pkg::t_prod r_p_xy, r_p_xz, r_p_yz;
    vms_pkg::t_prod r_p_sxy, r_p_sxz, r_p_syz;
    // Stage 2: grouped sums
    vms_pkg::t_acc  r_pos, r_neg, r_shr;
    // Stage 3: difference and tripled shear
    vms_pkg::t_acc  r_diff, r_shr3;
    // Stage 4: quadratic form
    vms_pkg::t_acc  n_sum;
    vms_pkg::t_quad r_q;

    assign n_sz  = i_kind ? i_normal_z : '0;
    assign n_txz = i_kind ? i_shear_xz : '0;
    assign n_tyz = i_kind ? i_shear_yz : '0;

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[vms_pkg::QUAD_STAGES-2:0], i_valid};
        end
    end

    // Multiply all component pairs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_xx  <= vms_pkg::PROD_W'(i_normal_x * i_normal_x);
            r_p_yy  <= vms_pkg::PROD_W'(i_normal_y * i_normal_y);
            r_p_zz  <= vms_pkg::PROD_W'(n_sz * n_sz);
            r_p_xy  <= vms_pkg::PROD_W'(i_normal_x * i_normal_y);
            r_p_xz  <= vms_pkg::PROD_W'(i_normal_x * n_sz);
            r_p_yz  <= vms_pkg::PROD_W'(i_normal_y * n_sz);
            r_p_sxy <= vms_pkg::PROD_W'(i_shear_xy * i_shear_xy);
            r_p_sxz <= vms_pkg::PROD_W'(n_txz * n_txz);
            r_p_syz <= vms_pkg::PROD_W'(n_tyz * n_tyz);
        end
    end

    // Sum squares, cross terms and shear squares separately
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos <= vms_pkg::ACC_W'(r_p_xx) + vms_pkg::ACC_W'(r_p_yy)
                   + vms_pkg::ACC_W'(r_p_zz);
            r_neg <= vms_pkg::ACC_W'(r_p_xy) + vms_pkg::ACC_W'(r_p_xz)
                   + vms_pkg::ACC_W'(r_p_yz);
            r_shr <= vms_pkg::ACC_W'(r_p_sxy) + vms_pkg::ACC_W'(r_p_sxz)
                   + vms_pkg::ACC_W'(r_p_syz);
        end
    end

    // Subtract cross terms, triple the shear sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= r_pos - r_neg;
            r_shr3 <= r_shr + (r_shr <<< 1);
        end
    end

    // Final form is non-negative and below 2^66
    assign n_sum = r_diff + r_shr3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_sum[vms_pkg::Q_W-1:0];
        end
    end

    assign o_valid = r_vld[vms_pkg::QUAD_STAGES-1];
    assign o_q     = r_q;

endmodule

@@ rtl/von_mises_stress.sv @@
// Top level: von Mises equivalent stress, quadratic form plus pipelined square root.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one stress tensor per transaction:
//   i_kind selects plane (0) or full 3-D (1); the six components are signed
//   Q16.16. In plane mode normal_z, shear_xz and shear_yz are ignored.
//   Output channel (o_valid / i_stall) carries one equivalent stress per
//   transaction, unsigned Q17.16, the floor of the exact square root.
//   Throughput: one transaction per cycle unless the receiver stalls; every
//   stage is fully pipelined. Path: four stages of multiply and sum, then
//   one root bit per stage for 33 stages, from input acceptance to o_valid.
//   Results leave in input order, one per input.
//   Reset (i_rst_n low at a clock edge) clears all valid bits; data in
//   flight is dropped and o_valid goes low.
//   When the receiver stalls while o_valid is high, the whole pipeline
//   holds and o_stall rises, so no transaction is lost or repeated.
//   Bubbles never stall the input: with o_valid low or i_stall low the
//   block takes a new transaction every cycle.
module von_mises_stress (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_kind,
    input  vms_pkg::t_comp i_normal_x,
    input  vms_pkg::t_comp i_normal_y,
    input  vms_pkg::t_comp i_normal_z,
    input  vms_pkg::t_comp i_shear_xy,
    input  vms_pkg::t_comp i_shear_xz,
    input  vms_pkg::t_comp i_shear_yz,
    output logic           o_valid,
    input  logic           i_stall,
    output vms_pkg::t_root o_equivalent_stress
);

    localparam int NB = vms_pkg::ROOT_W;

    logic            n_en;
    logic            quad_valid;
    vms_pkg::t_quad  quad_q;

    logic [NB-1:0]   r_vld;
    vms_pkg::t_quad  r_rem  [NB];
    vms_pkg::t_root  r_root [NB];

    // Hold every stage while a result waits on a stalled receiver
    assign n_en    = !(o_valid && i_stall);
    assign o_stall = !n_en;

    vms_quad u_quad (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (n_en),
        .i_valid    (i_valid),
        .i_kind     (i_kind),
        .i_normal_x (i_normal_x),
        .i_normal_y (i_normal_y),
        .i_normal_z (i_normal_z),
        .i_shear_xy (i_shear_xy),
        .i_shear_xz (i_shear_xz),
        .i_shear_yz (i_shear_yz),
        .o_valid    (quad_valid),
        .o_q        (quad_q)
    );

    // Advance root-stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[NB-2:0], quad_valid};
        end
    end

    // One root bit per stage, most significant first; r_rem holds q - root^2
    for (genvar j = 0; j < NB; j++) begin : g_root
        localparam int B = NB - 1 - j;

        vms_pkg::t_quad   rem_in;
        vms_pkg::t_root   root_in;
        logic [vms_pkg::Q_W:0] n_trial;
        logic             n_take;
        vms_pkg::t_quad   n_rem;
        vms_pkg::t_root   n_root;

        if (j == 0) begin : g_first
            assign rem_in  = quad_q;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        assign n_trial = ((vms_pkg::Q_W+1)'(root_in) << (B + 1))
                       | ((vms_pkg::Q_W+1)'(1) << (2 * B));
        assign n_take  = {1'b0, rem_in} >= n_trial;
        assign n_rem   = n_take ? rem_in - n_trial[vms_pkg::Q_W-1:0] : rem_in;
        assign n_root  = n_take ? (root_in | (vms_pkg::ROOT_W'(1) << B)) : root_in;

        always_ff @(posedge i_clk) begin
            if (n_en) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
            end
        end
    end

    assign o_valid             = r_vld[NB-1];
    assign o_equivalent_stress = r_root[NB-1];

    // Final remainder proves the root is the floor: q - r^2 <= 2r
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_rem[NB-1] <= vms_pkg::Q_W'({o_equivalent_stress, 1'b0})))
        else $error("root remainder exceeds 2*root");

    // A stalled output freezes all pipeline valid bits
    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

    // Nothing comes out right after a reset edge
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule
